[rtl/tsa_pkg.sv]
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types and constants of the tagged slot allocator.
// ----------------------------------------------------------------------------
package tsa_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int ID_W       = 64;
	localparam int IDX_W      = 6;
	localparam int OUTC_W     = 3;
	localparam int OUT_W      = 16;

	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef enum logic [OUTC_W-1:0] {
		OUTC_HIT      = 3'd0,
		OUTC_ALLOC    = 3'd1,
		OUTC_RELEASED = 3'd2,
		OUTC_ABSENT   = 3'd3,
		OUTC_FULL     = 3'd4
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN
	} state_t;

	// Strobes broadcast from the controller to every cell.
	typedef struct packed {
		logic tok_load;
		logic tok_adv;
		logic alloc_en;
		logic rel_en;
	} ctrl_t;

	// Status that each cell reports back.
	typedef struct packed {
		logic sel;
		logic free;
		logic tok;
	} cell_stat_t;

endpackage

[rtl/tsa_cell.sv]
// ----------------------------------------------------------------------------
// tsa_cell
// One slot of the pool: its tag, its compare and its share of the scan token.
// ----------------------------------------------------------------------------
module tsa_cell import tsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] cell_idx,
	input  ctrl_t             ctrl,
	input  logic [ID_W-1:0]   id,
	input  logic [SLOT_W-1:0] ptr,
	input  logic              tok_in,
	input  logic              found_in,
	output logic              found_out,
	output cell_stat_t        stat
);

	logic [ID_W-1:0] tag_q;
	logic            tok_q;
	logic            match;

	// A lower cell that already matched masks this one, so the lowest match wins.
	assign match     = (tag_q == id);
	assign found_out = found_in | match;
	assign stat.sel  = match & ~found_in;
	assign stat.free = (tag_q == '0);
	assign stat.tok  = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
			tok_q <= 1'b0;
		end else begin
			if (ctrl.alloc_en && tok_q) begin
				tag_q <= id;
			end else if (ctrl.rel_en && stat.sel) begin
				tag_q <= '0;
			end
			if (ctrl.tok_load) begin
				tok_q <= (cell_idx == ptr);
			end else if (ctrl.tok_adv) begin
				tok_q <= tok_in;
			end
		end
	end

endmodule

[rtl/tagged_slot_allocator_top.sv]
// ----------------------------------------------------------------------------
// tagged_slot_allocator_top
// Pool of tagged slots with lookup, round-robin allocation and release.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one request per transfer: the event id in s_tdata
// and the command in s_tuser (acquire or release). The master stream returns
// one result per request: the slot index and an outcome code.
// A request is registered on acceptance and the slots are looked up in the
// next cycle, all cells comparing in parallel. Hits, releases, absent ids and
// a full pool are resolved there, and the result register is loaded as soon
// as the output register is free; a new request is taken only after that.
// An acquire that misses starts a token at the scan pointer that walks the
// ring of cells one slot per cycle until it sits on a free slot; that slot
// is allocated once the output register is free.
// Reset clears every tag (all slots free), the scan pointer and the token.
// While a result waits in the output register, a new request is still taken
// and looked up; the block holds its decision, without touching any tag,
// until the receiver frees the output register.
// ----------------------------------------------------------------------------
module tagged_slot_allocator_top import tsa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [ID_W-1:0]  s_tdata,   // [63:0] event_id
	input  logic             s_tuser,   // [0] command
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // [5:0] slot_index, [8:6] outcome, rest zero
);

	state_t            state_q, state_nx;
	logic              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [SLOT_W-1:0] ptr_q;
	logic              m_valid_q;
	logic [IDX_W-1:0]  slot_q;
	outcome_t          outc_q;

	ctrl_t             ctrl;
	cell_stat_t        stat [SLOT_COUNT];
	logic [SLOT_COUNT:0] found;
	logic [SLOT_COUNT-1:0] sel_v, free_v, tok_v;
	logic [SLOT_W-1:0] sel_idx, tok_idx;
	logic              any_hit, any_free, tok_free, out_free;
	logic              look_done;
	logic              out_load;
	logic [IDX_W-1:0]  res_slot;
	outcome_t          res_outc;

	// Row of cells; the token moves from each cell to the next one in the ring.
	assign found[0] = 1'b0;
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		tsa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (SLOT_W'(i)),
			.ctrl      (ctrl),
			.id        (id_q),
			.ptr       (ptr_q),
			.tok_in    (stat[(i + SLOT_COUNT - 1) % SLOT_COUNT].tok),
			.found_in  (found[i]),
			.found_out (found[i+1]),
			.stat      (stat[i])
		);
		assign sel_v[i]  = stat[i].sel;
		assign free_v[i] = stat[i].free;
		assign tok_v[i]  = stat[i].tok;
	end

	// Both vectors are one-hot or empty, so an OR of indexes encodes them.
	always_comb begin
		sel_idx = '0;
		tok_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (sel_v[i]) sel_idx = sel_idx | SLOT_W'(i);
			if (tok_v[i]) tok_idx = tok_idx | SLOT_W'(i);
		end
	end

	assign any_hit   = found[SLOT_COUNT];
	assign any_free  = |free_v;
	assign tok_free  = |(tok_v & free_v);
	assign out_free  = ~m_valid_q | m_tready;
	// The lookup settles the request unless it is an acquire that must scan.
	assign look_done = (cmd_q == CMD_RELEASE) || any_hit || !any_free;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nx = ST_LOOK;
			end
			ST_LOOK: begin
				if (!look_done) state_nx = ST_SCAN;
				else if (out_free) state_nx = ST_IDLE;
			end
			ST_SCAN: begin
				if (tok_free && out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		s_tready      = 1'b0;
		ctrl          = '0;
		out_load      = 1'b0;
		res_slot      = '0;
		res_outc      = OUTC_HIT;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_LOOK: begin
				if (!look_done) begin
					ctrl.tok_load = 1'b1;
				end else if (out_free) begin
					out_load = 1'b1;
					if (cmd_q == CMD_RELEASE) begin
						ctrl.rel_en = any_hit;
						res_slot    = any_hit ? IDX_W'(sel_idx) : '0;
						res_outc    = any_hit ? OUTC_RELEASED : OUTC_ABSENT;
					end else begin
						res_slot = any_hit ? IDX_W'(sel_idx) : '0;
						res_outc = any_hit ? OUTC_HIT : OUTC_FULL;
					end
				end
			end
			ST_SCAN: begin
				if (tok_free) begin
					if (out_free) begin
						ctrl.alloc_en = 1'b1;
						out_load      = 1'b1;
						res_slot      = IDX_W'(tok_idx);
						res_outc      = OUTC_ALLOC;
					end
				end else begin
					ctrl.tok_adv = 1'b1;
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ptr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctrl.alloc_en) ptr_q <= tok_idx;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= s_tuser;
			id_q  <= s_tdata;
		end
		if (out_load) begin
			slot_q <= res_slot;
			outc_q <= res_outc;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_W - IDX_W - OUTC_W)'(0), outc_q, slot_q};

endmodule

[rtl/tsa_checker.sv]
// ----------------------------------------------------------------------------
// tsa_checker
// Port-level checks of the tagged slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module tsa_checker import tsa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// Only one request is in flight, so readiness drops after each transfer.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another was in flight");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:6] <= 3'(OUTC_FULL)))
		else $error("undefined outcome code");

	// Absent and full results carry no slot.
	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[8:6] == 3'(OUTC_ABSENT) || m_tdata[8:6] == 3'(OUTC_FULL))
		|-> (m_tdata[5:0] == '0))
		else $error("slot index set on absent or full result");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] < IDX_W'(SLOT_COUNT)))
		else $error("slot index beyond the pool");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind tagged_slot_allocator_top tsa_checker u_tsa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
